### sv/boad_pkg.sv
`timescale 1ns / 1ps
// shared types, codes and sizing constants for the ber oid arc decoder
// no dependencies
package boad_pkg;

    localparam int ARC_WIDTH         = 32;
    localparam int MAX_LENGTH_OCTETS = 4;
    localparam int LEN_CNT_W         = $clog2(MAX_LENGTH_OCTETS + 1);
    localparam int CONTENT_W         = 32;
    localparam int TAG_W             = 5;
    localparam int VALUE_W           = 32;
    localparam int QUEUE_DEPTH       = 3;
    localparam int QCNT_W            = $clog2(QUEUE_DEPTH + 1);

    localparam logic [TAG_W-1:0] TAG_RESET = TAG_W'(6);

    localparam logic [1:0] KIND_ARC   = 2'd0;
    localparam logic [1:0] KIND_ERROR = 2'd1;
    localparam logic [1:0] KIND_EMPTY = 2'd2;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_TAG       = 3'd1;
    localparam logic [2:0] ERR_LENGTH    = 3'd2;
    localparam logic [2:0] ERR_TRUNCATED = 3'd3;
    localparam logic [2:0] ERR_OVERFLOW  = 3'd4;

    typedef struct packed {
        logic [1:0]         kind;
        logic [VALUE_W-1:0] arc_value;
        logic [2:0]         error_code;
        logic               last;
    } t_result;

endpackage

### sv/boad_parser.sv
`timescale 1ns / 1ps
// element parser: tag check, length decode and base-128 arc gathering
// depends on boad_pkg
module boad_parser import boad_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [TAG_W-1:0] i_cfg_data,
    input  logic             i_fire,
    input  logic [7:0]       i_byte,
    input  logic             i_start,
    output t_result          o_res0,
    output t_result          o_res1,
    output logic [1:0]       o_count
);

    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_LEN     = 2'd1;
    localparam logic [1:0] PH_LENOCT  = 2'd2;
    localparam logic [1:0] PH_CONTENT = 2'd3;

    logic [TAG_W-1:0]     r_tag;
    logic [1:0]           r_phase, n_phase;
    logic [LEN_CNT_W-1:0] r_len_left, n_len_left;
    logic [CONTENT_W-1:0] r_content, n_content;
    logic [ARC_WIDTH-1:0] r_acc, n_acc;
    logic                 r_first, n_first;

    logic [CONTENT_W-1:0] content_dec;
    logic [CONTENT_W-1:0] content_shift;
    logic [LEN_CNT_W-1:0] len_dec;
    logic [ARC_WIDTH-1:0] acc_shift;
    logic [ARC_WIDTH-1:0] q_val, r_val;

    function automatic t_result mk(input logic [1:0] kind, input logic [VALUE_W-1:0] val,
                                   input logic [2:0] err, input logic last);
        t_result res;
        res.kind       = kind;
        res.arc_value  = val;
        res.error_code = err;
        res.last       = last;
        return res;
    endfunction

    assign content_dec   = r_content - CONTENT_W'(1);
    assign content_shift = {r_content[CONTENT_W-9:0], i_byte};
    assign len_dec       = r_len_left - LEN_CNT_W'(1);
    assign acc_shift     = {r_acc[ARC_WIDTH-8:0], i_byte[6:0]};

    always_comb begin
        if (acc_shift < ARC_WIDTH'(40)) begin
            q_val = ARC_WIDTH'(0);
            r_val = acc_shift;
        end else if (acc_shift < ARC_WIDTH'(80)) begin
            q_val = ARC_WIDTH'(1);
            r_val = acc_shift - ARC_WIDTH'(40);
        end else begin
            q_val = ARC_WIDTH'(2);
            r_val = acc_shift - ARC_WIDTH'(80);
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_len_left = r_len_left;
        n_content  = r_content;
        n_acc      = r_acc;
        n_first    = r_first;
        o_count    = 2'd0;
        o_res0     = mk(KIND_ARC, VALUE_W'(0), ERR_NONE, 1'b0);
        o_res1     = mk(KIND_ARC, VALUE_W'(0), ERR_NONE, 1'b0);
        if (i_start) begin
            n_len_left = '0;
            n_content  = '0;
            n_acc      = '0;
            n_first    = 1'b1;
            if (i_byte[TAG_W-1:0] != r_tag) begin
                n_phase = PH_IDLE;
                o_count = 2'd1;
                o_res0  = mk(KIND_ERROR, VALUE_W'(0), ERR_TAG, 1'b1);
            end else begin
                n_phase = PH_LEN;
            end
        end else begin
            case (r_phase)
                PH_LEN: begin
                    if (!i_byte[7]) begin
                        n_content = CONTENT_W'(i_byte);
                        if (i_byte == 8'd0) begin
                            n_phase = PH_IDLE;
                            o_count = 2'd1;
                            o_res0  = mk(KIND_EMPTY, VALUE_W'(0), ERR_NONE, 1'b1);
                        end else begin
                            n_phase = PH_CONTENT;
                        end
                    end else if (32'(i_byte[6:0]) > 32'(MAX_LENGTH_OCTETS)) begin
                        n_len_left = '0;
                        n_phase    = PH_IDLE;
                        o_count    = 2'd1;
                        o_res0     = mk(KIND_ERROR, VALUE_W'(0), ERR_LENGTH, 1'b1);
                    end else begin
                        n_len_left = LEN_CNT_W'(i_byte[6:0]);
                        n_content  = '0;
                        if (i_byte[6:0] == 7'd0) begin
                            n_phase = PH_IDLE;
                            o_count = 2'd1;
                            o_res0  = mk(KIND_EMPTY, VALUE_W'(0), ERR_NONE, 1'b1);
                        end else begin
                            n_phase = PH_LENOCT;
                        end
                    end
                end
                PH_LENOCT: begin
                    if (r_content[CONTENT_W-1:CONTENT_W-8] != 8'd0) begin
                        n_phase = PH_IDLE;
                        o_count = 2'd1;
                        o_res0  = mk(KIND_ERROR, VALUE_W'(0), ERR_LENGTH, 1'b1);
                    end else begin
                        n_content  = content_shift;
                        n_len_left = len_dec;
                        if (len_dec == '0) begin
                            if (content_shift == '0) begin
                                n_phase = PH_IDLE;
                                o_count = 2'd1;
                                o_res0  = mk(KIND_EMPTY, VALUE_W'(0), ERR_NONE, 1'b1);
                            end else begin
                                n_acc   = '0;
                                n_phase = PH_CONTENT;
                            end
                        end
                    end
                end
                PH_CONTENT: begin
                    if (r_acc[ARC_WIDTH-1:ARC_WIDTH-7] != 7'd0) begin
                        n_phase = PH_IDLE;
                        o_count = 2'd1;
                        o_res0  = mk(KIND_ERROR, VALUE_W'(0), ERR_OVERFLOW, 1'b1);
                    end else begin
                        n_acc     = acc_shift;
                        n_content = content_dec;
                        if (i_byte[7]) begin
                            if (content_dec == '0) begin
                                n_phase = PH_IDLE;
                                o_count = 2'd1;
                                o_res0  = mk(KIND_ERROR, VALUE_W'(0), ERR_TRUNCATED, 1'b1);
                            end
                        end else begin
                            n_acc = '0;
                            if (content_dec == '0) begin
                                n_phase = PH_IDLE;
                            end
                            if (r_first) begin
                                n_first = 1'b0;
                                o_count = 2'd2;
                                o_res0  = mk(KIND_ARC, VALUE_W'(q_val), ERR_NONE, 1'b0);
                                o_res1  = mk(KIND_ARC, VALUE_W'(r_val), ERR_NONE,
                                             content_dec == '0);
                            end else begin
                                o_count = 2'd1;
                                o_res0  = mk(KIND_ARC, VALUE_W'(acc_shift), ERR_NONE,
                                             content_dec == '0);
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag      <= TAG_RESET;
            r_phase    <= PH_IDLE;
            r_len_left <= '0;
            r_content  <= '0;
            r_acc      <= '0;
            r_first    <= 1'b1;
        end else begin
            if (i_cfg_we) begin
                r_tag <= i_cfg_data;
            end
            if (i_fire) begin
                r_phase    <= n_phase;
                r_len_left <= n_len_left;
                r_content  <= n_content;
                r_acc      <= n_acc;
                r_first    <= n_first;
            end
        end
    end

endmodule

### sv/boad_result_queue.sv
`timescale 1ns / 1ps
// short shifting result queue, takes up to two results per cycle, head drives the output
// depends on boad_pkg
module boad_result_queue import boad_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic [1:0] i_count,
    input  t_result    i_res0,
    input  t_result    i_res1,
    output logic       o_room,
    output logic       o_valid,
    input  logic       i_stall,
    output t_result    o_head
);

    t_result            r_slot [QUEUE_DEPTH];
    t_result            n_slot [QUEUE_DEPTH];
    t_result            ext    [QUEUE_DEPTH+1];
    logic [QCNT_W-1:0]  r_count, n_count;
    logic [QCNT_W-1:0]  cnt_after;
    logic [QCNT_W-1:0]  push_n;
    logic               pop;

    assign pop       = (r_count != '0) && !i_stall;
    assign cnt_after = r_count - QCNT_W'(pop);
    assign o_room    = cnt_after <= QCNT_W'(QUEUE_DEPTH - 2);
    assign push_n    = i_push ? QCNT_W'(i_count) : '0;
    assign n_count   = cnt_after + push_n;
    assign o_valid   = r_count != '0;
    assign o_head    = r_slot[0];

    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            ext[i] = r_slot[i];
        end
        ext[QUEUE_DEPTH] = r_slot[QUEUE_DEPTH-1];
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (QCNT_W'(i) < cnt_after) begin
                n_slot[i] = pop ? ext[i+1] : r_slot[i];
            end else if (QCNT_W'(i) == cnt_after && push_n != '0) begin
                n_slot[i] = i_res0;
            end else if (QCNT_W'(i) == cnt_after + QCNT_W'(1) && push_n == QCNT_W'(2)) begin
                n_slot[i] = i_res1;
            end else begin
                n_slot[i] = r_slot[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            r_slot[i] <= n_slot[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

endmodule

### sv/ber_oid_arc_decoder_core.sv
`timescale 1ns / 1ps
// top level of the ber object identifier arc decoder
// depends on boad_pkg, boad_parser and boad_result_queue
//
// Takes the bytes of a BER object identifier element one per transfer, with
// i_start_req marking the tag byte, and returns the decoded arcs (the first arc
// split into two), an empty-content result or an error, with o_last on the
// final result of each element. Each byte passes through an input register and
// is parsed combinationally into a three-entry result queue, so a byte is taken
// every cycle while the output side keeps up; the queue drains one result per
// cycle while i_stall is low, so a byte that completes the first arc yields two
// results, which reach the output through the input register and the queue. i_cfg_data
// (the expected low tag number, reset 6) should be written only while idle.
module ber_oid_arc_decoder_core import boad_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [TAG_W-1:0]   i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_in_byte,
    input  logic               i_start_req,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_kind,
    output logic [VALUE_W-1:0] o_arc_value,
    output logic [2:0]         o_error_code,
    output logic               o_last
);

    logic       r_in_valid;
    logic [7:0] r_byte;
    logic       r_start;
    logic       room;
    logic       fire;
    t_result    res0, res1, head;
    logic [1:0] res_count;

    assign fire    = r_in_valid && room;
    assign o_stall = r_in_valid && !room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_byte  <= i_in_byte;
            r_start <= i_start_req;
        end
    end

    boad_parser u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_fire     (fire),
        .i_byte     (r_byte),
        .i_start    (r_start),
        .o_res0     (res0),
        .o_res1     (res1),
        .o_count    (res_count)
    );

    boad_result_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fire),
        .i_count (res_count),
        .i_res0  (res0),
        .i_res1  (res1),
        .o_room  (room),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_head  (head)
    );

    assign o_kind       = head.kind;
    assign o_arc_value  = head.arc_value;
    assign o_error_code = head.error_code;
    assign o_last       = head.last;

endmodule

### verif/ber_oid_arc_decoder_checker.sv
`timescale 1ns / 1ps
// checker for ber_oid_arc_decoder_core: watches the byte, result and tag write ports,
// predicts the arc, empty and error results and compares them in order
// depends on boad_pkg
module ber_oid_arc_decoder_checker import boad_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [TAG_W-1:0]   i_cfg_data,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic [7:0]         i_in_byte,
    input  logic               i_start_req,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [1:0]         i_kind,
    input  logic [VALUE_W-1:0] i_arc_value,
    input  logic [2:0]         i_error_code,
    input  logic               i_last,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_arcs,
    output int                 o_errors,
    output int                 o_empties
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LENGTH,
        ST_LEN_OCTETS,
        ST_CONTENT
    } t_parse_state;

    localparam logic [63:0] ARC_MASK = {64{1'b1}} >> (64 - ARC_WIDTH);

    t_parse_state     pstate;
    logic [TAG_W-1:0] tag_cfg;
    logic [2:0]       len_left;
    logic [31:0]      remaining;
    logic [63:0]      acc;
    logic             first_pending;
    t_result          expected_results[$];
    t_result          want;

    function automatic void emit(input logic [1:0] k, input logic [VALUE_W-1:0] v,
                                 input logic [2:0] e, input logic l);
        t_result r;
        r.kind       = k;
        r.arc_value  = v;
        r.error_code = e;
        r.last       = l;
        expected_results.push_back(r);
    endfunction

    function automatic void close_element(input logic [1:0] k, input logic [2:0] e);
        emit(k, '0, e, 1'b1);
        pstate = ST_IDLE;
    endfunction

    function automatic void decode_byte(input logic [7:0] b, input logic s);
        logic [6:0] count;
        logic       fin;
        if (s) begin
            len_left      = '0;
            remaining     = '0;
            acc           = '0;
            first_pending = 1'b1;
            if (b[4:0] != tag_cfg) close_element(KIND_ERROR, ERR_TAG);
            else pstate = ST_LENGTH;
        end else begin
            case (pstate)
                ST_LENGTH: begin
                    if (!b[7]) begin
                        remaining = {24'd0, b};
                        if (b == 8'd0) close_element(KIND_EMPTY, ERR_NONE);
                        else pstate = ST_CONTENT;
                    end else begin
                        count = b[6:0];
                        if (count > MAX_LENGTH_OCTETS) begin
                            len_left = '0;
                            close_element(KIND_ERROR, ERR_LENGTH);
                        end else begin
                            len_left  = count[2:0];
                            remaining = '0;
                            if (count == 7'd0) close_element(KIND_EMPTY, ERR_NONE);
                            else pstate = ST_LEN_OCTETS;
                        end
                    end
                end
                ST_LEN_OCTETS: begin
                    if (remaining[31:24] != 8'd0) begin
                        close_element(KIND_ERROR, ERR_LENGTH);
                    end else begin
                        remaining = {remaining[23:0], b};
                        len_left  = len_left - 3'd1;
                        if (len_left == 3'd0) begin
                            if (remaining == 32'd0) begin
                                close_element(KIND_EMPTY, ERR_NONE);
                            end else begin
                                acc    = '0;
                                pstate = ST_CONTENT;
                            end
                        end
                    end
                end
                ST_CONTENT: begin
                    if ((acc >> (ARC_WIDTH - 7)) != 64'd0) begin
                        close_element(KIND_ERROR, ERR_OVERFLOW);
                    end else begin
                        acc       = ((acc << 7) | {57'd0, b[6:0]}) & ARC_MASK;
                        remaining = remaining - 32'd1;
                        if (b[7]) begin
                            if (remaining == 32'd0) close_element(KIND_ERROR, ERR_TRUNCATED);
                        end else begin
                            fin = (remaining == 32'd0);
                            if (fin) pstate = ST_IDLE;
                            if (first_pending) begin
                                if (acc < 64'd80) begin
                                    emit(KIND_ARC, VALUE_W'(acc / 64'd40), ERR_NONE, 1'b0);
                                    emit(KIND_ARC, VALUE_W'(acc % 64'd40), ERR_NONE, fin);
                                end else begin
                                    emit(KIND_ARC, VALUE_W'(2), ERR_NONE, 1'b0);
                                    emit(KIND_ARC, VALUE_W'(acc - 64'd80), ERR_NONE, fin);
                                end
                                first_pending = 1'b0;
                            end else begin
                                emit(KIND_ARC, VALUE_W'(acc), ERR_NONE, fin);
                            end
                            acc = '0;
                        end
                    end
                end
                default: ;
            endcase
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pstate        = ST_IDLE;
            tag_cfg       = TAG_RESET;
            len_left      = '0;
            remaining     = '0;
            acc           = '0;
            first_pending = 1'b1;
            o_fail_count  = 0;
            o_arcs        = 0;
            o_errors      = 0;
            o_empties     = 0;
            expected_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                case (i_kind)
                    KIND_ARC:   o_arcs++;
                    KIND_ERROR: o_errors++;
                    KIND_EMPTY: o_empties++;
                    default: ;
                endcase
                if (expected_results.size() == 0) begin
                    $error("unexpected result: kind %0d value %0h error %0d last %0d",
                           i_kind, i_arc_value, i_error_code, i_last);
                    o_fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (i_kind !== want.kind) begin
                        $error("kind: expected %0d, actual %0d", want.kind, i_kind);
                        o_fail_count++;
                    end
                    if (i_arc_value !== want.arc_value) begin
                        $error("arc_value: expected %0h, actual %0h", want.arc_value,
                               i_arc_value);
                        o_fail_count++;
                    end
                    if (i_error_code !== want.error_code) begin
                        $error("error_code: expected %0d, actual %0d", want.error_code,
                               i_error_code);
                        o_fail_count++;
                    end
                    if (i_last !== want.last) begin
                        $error("last: expected %0d, actual %0d", want.last, i_last);
                        o_fail_count++;
                    end
                end
            end
            if (i_cfg_we) tag_cfg = i_cfg_data;
            if (i_in_valid && !i_in_stall) decode_byte(i_in_byte, i_start_req);
        end
        o_pending = expected_results.size();
    end

endmodule

### verif/ber_oid_arc_decoder_core_tb.sv
`timescale 1ns / 1ps
// testbench top for ber_oid_arc_decoder_core: reset, directed and random oid elements
// under several tag settings, random idling on both sides, verdict from the checker
// depends on boad_pkg, ber_oid_arc_decoder_core and ber_oid_arc_decoder_checker
module ber_oid_arc_decoder_core_tb;
    import boad_pkg::*;

    localparam int HALF_PERIOD  = 5;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 60;
    localparam int RANDOM_BYTES = 500;
    localparam int N_PHASES     = 5;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_cfg_we    = 1'b0;
    logic [TAG_W-1:0]   i_cfg_data  = TAG_RESET;
    logic               i_valid     = 1'b0;
    logic               o_stall;
    logic [7:0]         i_in_byte   = 8'd0;
    logic               i_start_req = 1'b0;
    logic               o_valid;
    logic               i_stall     = 1'b0;
    logic [1:0]         o_kind;
    logic [VALUE_W-1:0] o_arc_value;
    logic [2:0]         o_error_code;
    logic               o_last;

    int                 fail_count;
    int                 pending;
    int                 arcs_seen;
    int                 errors_seen;
    int                 empties_seen;

    bit                 quiet      = 1'b0;
    bit                 hold_req   = 1'b0;
    bit                 hold_done  = 1'b0;
    int unsigned        bytes_sent = 0;
    int unsigned        cycles     = 0;
    int unsigned        tag_writes = 0;
    logic [TAG_W-1:0]   tag_now    = TAG_RESET;
    logic [TAG_W-1:0]   phase_tag[N_PHASES];
    logic [7:0]         oid_bytes[$];
    logic [7:0]         body[$];

    ber_oid_arc_decoder_core i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_in_byte    (i_in_byte),
        .i_start_req  (i_start_req),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_kind       (o_kind),
        .o_arc_value  (o_arc_value),
        .o_error_code (o_error_code),
        .o_last       (o_last)
    );

    ber_oid_arc_decoder_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_valid),
        .i_in_stall   (o_stall),
        .i_in_byte    (i_in_byte),
        .i_start_req  (i_start_req),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_kind       (o_kind),
        .i_arc_value  (o_arc_value),
        .i_error_code (o_error_code),
        .i_last       (o_last),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_arcs       (arcs_seen),
        .o_errors     (errors_seen),
        .o_empties    (empties_seen)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // result side: random stall bursts, one long hold-off on request
    initial begin
        int burst;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                burst = $urandom_range(1, 4);
                i_stall <= 1'b1;
                repeat (burst - 1) @(negedge i_clk);
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic s);
        int gap;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 4);
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_in_byte   <= b;
        i_start_req <= s;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_oid();
        foreach (oid_bytes[i]) send_byte(oid_bytes[i], i == 0);
    endtask

    function automatic void push_arc(input logic [31:0] v, input int pads);
        int          groups;
        logic [63:0] w;
        w      = {32'd0, v};
        groups = 1;
        while (groups < 5 && (w >> (7 * groups)) != 64'd0) groups++;
        repeat (pads) body.push_back(8'h80);
        for (int g = groups - 1; g >= 0; g--) body.push_back({g != 0, w[7*g +: 7]});
    endfunction

    function automatic logic [31:0] pick_arc();
        case ($urandom_range(0, 7))
            0:       return $urandom_range(0, 127);
            1:       return 39 + 40 * $urandom_range(0, 1) + $urandom_range(0, 1);
            2:       return $urandom_range(128, 16383);
            3:       return 32'hFFFF_FFFF;
            4:       return $urandom;
            5:       return 32'd0;
            default: return $urandom_range(0, 2097151);
        endcase
    endfunction

    function automatic void push_length(input int unsigned n, input bit long_form,
                                        input int octets);
        int need;
        int cnt;
        need = 1;
        while (need < 4 && (n >> (8 * need)) != 0) need++;
        if (!long_form && n < 128) begin
            oid_bytes.push_back(8'(n));
        end else begin
            cnt = (octets < need) ? need : octets;
            oid_bytes.push_back(8'h80 | 8'(cnt));
            for (int k = cnt - 1; k >= 0; k--) oid_bytes.push_back(8'(n >> (8 * k)));
        end
    endfunction

    task automatic random_element();
        int narcs;
        int mode;
        int len;
        oid_bytes.delete();
        body.delete();
        narcs = $urandom_range(1, 4);
        for (int k = 0; k < narcs; k++)
            push_arc(pick_arc(), ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : 0);
        // arc wider than 32 bits
        if ($urandom_range(0, 11) == 0) begin
            body.push_back(8'h80 | 8'($urandom_range(16, 127)));
            repeat (4) body.push_back(8'h80 | 8'($urandom_range(0, 127)));
            body.push_back(8'($urandom_range(0, 127)));
        end
        if ($urandom_range(0, 9) == 0) oid_bytes.push_back(8'($urandom));
        else oid_bytes.push_back({3'($urandom), tag_now});
        mode = $urandom_range(0, 19);
        len  = body.size();
        case (mode)
            0:       oid_bytes.push_back(8'($urandom_range(8'h85, 8'hFF)));
            1:       len = len - 1;
            3:       len = len + $urandom_range(1, 3);
            4:       len = 0;
            default: ;
        endcase
        if (mode != 0) push_length(len, $urandom_range(0, 3) == 0, $urandom_range(1, 4));
        foreach (body[i]) oid_bytes.push_back(body[i]);
        // cut the element short, the next tag byte aborts it
        if (mode == 2) repeat ($urandom_range(1, oid_bytes.size() - 1)) void'(oid_bytes.pop_back());
        send_oid();
        if ($urandom_range(0, 15) == 0) send_byte(8'($urandom), 1'b0);
    endtask

    task automatic settle(input int extra);
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (extra) @(negedge i_clk);
    endtask

    task automatic write_tag(input logic [TAG_W-1:0] t);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= t;
        tag_now     = t;
        tag_writes++;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    initial begin
        int unsigned target;
        phase_tag[0] = 5'd0;
        phase_tag[1] = 5'd31;
        phase_tag[2] = 5'($urandom);
        phase_tag[3] = 5'($urandom);
        phase_tag[4] = TAG_RESET;

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed elements under the reset tag
        oid_bytes = '{8'hC6, 8'h84, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00};
        send_oid();
        oid_bytes = '{8'h06, 8'h00};
        send_oid();
        oid_bytes = '{8'h06, 8'h80};
        send_oid();
        oid_bytes = '{8'h06, 8'h81, 8'h00};
        send_oid();
        oid_bytes = '{8'hE7};
        send_oid();
        oid_bytes = '{8'h06, 8'h85};
        send_oid();
        oid_bytes = '{8'h06, 8'h08, 8'h80, 8'h81, 8'h7F, 8'h8F, 8'hFF, 8'hFF, 8'hFF, 8'h7F};
        send_oid();
        oid_bytes = '{8'h06, 8'h05, 8'h90, 8'h80, 8'h80, 8'h80, 8'h80};
        send_oid();
        oid_bytes = '{8'h06, 8'h01, 8'h81};
        send_oid();
        send_byte(8'h55, 1'b0);
        oid_bytes = '{8'h06, 8'h03, 8'h81};
        send_oid();
        oid_bytes = '{8'h06, 8'h01, 8'h4F};
        send_oid();

        for (int p = 0; p < N_PHASES; p++) begin
            settle(4);
            write_tag(phase_tag[p]);
            if (p == 1) hold_req = 1'b1;
            if (p == N_PHASES - 1) quiet = 1'b1;
            target = bytes_sent + RANDOM_BYTES / N_PHASES;
            while (bytes_sent < target) random_element();
        end

        settle(8);
        $display("summary: %0d bytes over %0d tag settings, %0d arcs, %0d errors, %0d empty",
                 bytes_sent, tag_writes + 1, arcs_seen, errors_seen, empties_seen);
        if (fail_count == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end

endmodule
